>>> rtl/core/cuwa_pkg.sv
// Shared types and constants for the cpu utilization window averager.
// No dependencies; imported by the adder unit and the top level.
`default_nettype none

package cuwa_pkg;

  // Usage is percent with 8 fraction bits, 0..25600
  localparam int QW         = 15;
  localparam int FRAC_BITS  = 8;
  localparam int FULL_SCALE = 100 << FRAC_BITS;

  // Counter and shared adder widths: busy * 100 fits in 71 bits
  localparam int CTR_W  = 64;
  localparam int AW     = 72;
  // Pre-shift so that the dividend's top part starts below the divisor
  localparam int PRE_SH = QW - FRAC_BITS;

  // Query window lengths and their select codes
  localparam int WIN_SHORT = 60;
  localparam int WIN_MID   = 5 * 60;
  localparam int WIN_LONG  = 15 * 60;
  localparam logic [1:0] SEL_MID  = 2'd1;
  localparam logic [1:0] SEL_LONG = 2'd2;

  localparam logic OP_SAMPLE = 1'b0;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [2:0] {
    PH_NONE = 3'b001,
    PH_BASE = 3'b010,
    PH_RUN  = 3'b100
  } phase_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DT   = 11'b000_0000_0010,
    S_DI   = 11'b000_0000_0100,
    S_BUSY = 11'b000_0000_1000,
    S_M3   = 11'b000_0001_0000,
    S_M100 = 11'b000_0010_0000,
    S_DIV  = 11'b000_0100_0000,
    S_WR   = 11'b000_1000_0000,
    S_FILL = 11'b001_0000_0000,
    S_QSUM = 11'b010_0000_0000,
    S_QOUT = 11'b100_0000_0000
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/cuwa_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module cuwa_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 900
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cuwa_alu.sv
// Shared add/subtract unit; subtract also reports a borrow (a < b).
// Depends on cuwa_pkg.
`default_nettype none

module cuwa_alu
  import cuwa_pkg::*;
(
  input  wire logic [AW-1:0] a,
  input  wire logic [AW-1:0] b,
  input  wire alu_op_t       op,
  output      logic [AW-1:0] y,
  output      logic          borrow
);

  logic [AW:0] y_full;
  logic [AW:0] b_ext;

  always_comb begin
    b_ext  = (op == ALU_SUB) ? {1'b0, ~b} : {1'b0, b};
    y_full = {1'b0, a} + b_ext + (AW + 1)'(op == ALU_SUB);
    y      = y_full[AW-1:0];
    borrow = (op == ALU_SUB) && !y_full[AW];
  end

endmodule

`default_nettype wire

>>> rtl/core/cpu_utilization_window_averager.sv
// CPU utilization window averager: top level with sequencer and datapath.
// Depends on cuwa_pkg, cuwa_alu and cuwa_ram.
//
// One item at a time; in_stall is high while an item is in progress. The
// deltas, the multiply, the division steps and the query sum all go
// through one shared 72-bit adder/subtractor, and the ring sits in one RAM
// with a single read port. A baseline sample (first after reset) only
// stores the counters and does not raise in_stall. A normal sample takes
// the deltas, the busy time and busy * 100, then 15 restoring-division
// steps; a zero total delta skips the division. The priming sample (second
// after reset) adds a pass that writes every ring slot. A query reads and
// sums the window's ring slots through the adder, then runs 15 division
// steps and loads the output register once the previous result has gone.
// No clearing pass runs after reset: until priming the ring reads as zero.
`default_nettype none

module cpu_utilization_window_averager
  import cuwa_pkg::*;
#(
  parameter int RING_SLOTS = 900
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire logic             operation,
  input  wire logic [CTR_W-1:0] total_ticks,
  input  wire logic [CTR_W-1:0] idle_ticks,
  input  wire logic [1:0]       window_select,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      logic [QW-1:0]    average_usage
);

  localparam int PW    = $clog2(RING_SLOTS);
  localparam int CW    = $clog2(RING_SLOTS + 1);
  localparam int SUM_W = $clog2(RING_SLOTS * FULL_SCALE + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(RING_SLOTS - 1);

  state_t state;
  phase_t phase;

  logic [PW-1:0]    write_slot;
  logic [PW-1:0]    fill_ptr;
  logic [PW-1:0]    ptr;
  logic [CTR_W-1:0] last_total;
  logic [CTR_W-1:0] last_idle;
  logic [CTR_W-1:0] tot_in;
  logic [CTR_W-1:0] idl_in;
  logic [CTR_W-1:0] divisor;
  logic [CTR_W-1:0] di;
  logic [CTR_W-1:0] busy;
  logic [CTR_W-1:0] rem;
  logic [AW-1:0]    acc;
  logic [QW-1:0]    dq;
  logic [QW-1:0]    quo;
  logic [QW-1:0]    value;
  logic [3:0]       step;
  logic [CW-1:0]    qcnt;
  logic [CW-1:0]    qiss;
  logic             rd_pend;
  logic             div_ratio;

  logic [PW-1:0]    slot_prev;
  logic [PW-1:0]    ptr_dec;
  logic [PW-1:0]    slot_inc;
  logic [CW-1:0]    win_cnt;
  logic [CTR_W:0]   shifted;
  logic [QW-1:0]    quo_next;
  logic [CTR_W-1:0] rem_next;
  logic             q_more;

  logic [AW-1:0]    alu_a;
  logic [AW-1:0]    alu_b;
  alu_op_t          alu_op;
  logic [AW-1:0]    alu_y;
  logic             alu_borrow;

  logic             ram_we;
  logic [PW-1:0]    ram_waddr;
  logic             ram_re;
  logic [PW-1:0]    ram_raddr;
  logic [QW-1:0]    ram_rdata;
  logic [QW-1:0]    ring_val;

  assign in_stall  = (state != S_IDLE);
  assign slot_prev = (write_slot == '0) ? LAST_SLOT : write_slot - 1'b1;
  assign ptr_dec   = (ptr == '0) ? LAST_SLOT : ptr - 1'b1;
  assign slot_inc  = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
  assign q_more    = (qiss != qcnt);
  // Ring reads as zero until the priming sample has filled it
  assign ring_val  = (phase == PH_RUN) ? ram_rdata : '0;

  always_comb begin
    int unsigned win_raw;
    win_raw = WIN_SHORT;
    case (window_select)
      SEL_MID:  win_raw = WIN_MID;
      SEL_LONG: win_raw = WIN_LONG;
      default:  win_raw = WIN_SHORT;
    endcase
    win_cnt = CW'((win_raw > RING_SLOTS) ? RING_SLOTS : win_raw);
  end

  // One restoring-division step
  assign shifted  = {rem, dq[QW-1]};
  assign quo_next = {quo[QW-2:0], !alu_borrow};
  assign rem_next = alu_borrow ? shifted[CTR_W-1:0] : alu_y[CTR_W-1:0];

  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = ALU_ADD;
    case (state)
      S_DT: begin
        alu_a  = AW'(tot_in);
        alu_b  = AW'(last_total);
        alu_op = ALU_SUB;
      end
      S_DI: begin
        alu_a  = AW'(idl_in);
        alu_b  = AW'(last_idle);
        alu_op = ALU_SUB;
      end
      S_BUSY: begin
        alu_a  = AW'(divisor);
        alu_b  = AW'(di);
        alu_op = ALU_SUB;
      end
      S_M3: begin
        alu_a = AW'(busy) << 1;
        alu_b = AW'(busy);
      end
      S_M100: begin
        // busy * 100 = busy * 3 * 32 + busy * 4
        alu_a = acc << 5;
        alu_b = AW'(busy) << 2;
      end
      S_DIV: begin
        alu_a  = AW'(shifted);
        alu_b  = AW'(divisor);
        alu_op = ALU_SUB;
      end
      S_QSUM: begin
        alu_a = acc;
        alu_b = AW'(ring_val);
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  cuwa_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .op     (alu_op),
    .y      (alu_y),
    .borrow (alu_borrow)
  );

  assign ram_we    = (state == S_WR) || (state == S_FILL);
  assign ram_waddr = (state == S_FILL) ? fill_ptr : write_slot;
  assign ram_re    = (state == S_DT) || ((state == S_QSUM) && q_more);
  assign ram_raddr = (state == S_DT) ? slot_prev : ptr;

  cuwa_ram #(
    .WIDTH (QW),
    .DEPTH (RING_SLOTS)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_NONE;
      write_slot <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (operation == OP_SAMPLE) begin
              if (phase == PH_NONE) begin
                last_total <= total_ticks;
                last_idle  <= idle_ticks;
                phase      <= PH_BASE;
                write_slot <= '0;
              end else begin
                tot_in <= total_ticks;
                idl_in <= idle_ticks;
                state  <= S_DT;
              end
            end else begin
              qcnt    <= win_cnt;
              qiss    <= '0;
              rd_pend <= 1'b0;
              acc     <= '0;
              ptr     <= slot_prev;
              state   <= S_QSUM;
            end
          end
        end
        S_DT: begin
          divisor <= alu_y[CTR_W-1:0];
          state   <= S_DI;
        end
        S_DI: begin
          di    <= alu_y[CTR_W-1:0];
          state <= S_BUSY;
        end
        S_BUSY: begin
          if (divisor == '0) begin
            value <= ring_val;
            state <= S_WR;
          end else if (alu_borrow) begin
            value <= '0;
            state <= S_WR;
          end else begin
            busy  <= alu_y[CTR_W-1:0];
            state <= S_M3;
          end
        end
        S_M3: begin
          acc   <= alu_y;
          state <= S_M100;
        end
        S_M100: begin
          // dividend = busy * 25600; its part above the quotient bits
          rem       <= alu_y[PRE_SH +: CTR_W];
          dq        <= {alu_y[PRE_SH-1:0], FRAC_BITS'(0)};
          quo       <= '0;
          step      <= '0;
          div_ratio <= 1'b1;
          state     <= S_DIV;
        end
        S_DIV: begin
          rem  <= rem_next;
          quo  <= quo_next;
          dq   <= dq << 1;
          step <= step + 1'b1;
          if (step == 4'(QW - 1)) begin
            if (div_ratio) begin
              value <= quo_next;
              state <= S_WR;
            end else begin
              state <= S_QOUT;
            end
          end
        end
        S_WR: begin
          write_slot <= slot_inc;
          last_total <= tot_in;
          last_idle  <= idl_in;
          if (phase == PH_BASE) begin
            phase    <= PH_RUN;
            fill_ptr <= '0;
            state    <= S_FILL;
          end else begin
            state <= S_IDLE;
          end
        end
        S_FILL: begin
          fill_ptr <= fill_ptr + 1'b1;
          if (fill_ptr == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end
        S_QSUM: begin
          if (q_more) begin
            ptr  <= ptr_dec;
            qiss <= qiss + 1'b1;
          end
          rd_pend <= q_more;
          if (rd_pend) begin
            acc <= alu_y;
          end
          if (!q_more && !rd_pend) begin
            // mean stays below 2^15, so sum >> 15 is below the count
            rem       <= CTR_W'(acc[SUM_W-1:QW]);
            dq        <= acc[QW-1:0];
            divisor   <= CTR_W'(qcnt);
            quo       <= '0;
            step      <= '0;
            div_ratio <= 1'b0;
            state     <= S_DIV;
          end
        end
        S_QOUT: begin
          // wait for the previous beat to leave the output register
          if (!out_valid) begin
            out_valid     <= 1'b1;
            average_usage <= quo;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Division remainder must stay below the divisor for the quotient to fit
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < divisor))
    else $error("division remainder not below divisor");

  a_out_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_QOUT))
    else $error("result raised outside query completion");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (average_usage <= QW'(FULL_SCALE)))
    else $error("average above full scale");

  a_fill_running: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> ((phase == PH_RUN) && (write_slot == PW'(1 % RING_SLOTS))))
    else $error("ring fill outside priming");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (write_slot <= LAST_SLOT) && (ptr <= LAST_SLOT || state != S_QSUM))
    else $error("ring index out of range");

endmodule

`default_nettype wire
